FILE: src/fspa_pkg.sv
// ----------------------------------------------------------------------------
// fspa_pkg
// Shared widths, codes and handshake types of the fixed slot pool allocator.
// ----------------------------------------------------------------------------
package fspa_pkg;

	localparam int ELEM_W    = 17;
	localparam int ALIGN_W   = 13;
	localparam int TOTAL_W   = 11;
	localparam int USED_W    = 11;
	localparam int STRIDE_W  = 17;
	localparam int DIV_W     = 17;
	localparam int STEP_W    = 5;
	localparam int CFG_IDX_W = 3;

	localparam logic [ELEM_W-1:0]  MIN_STRIDE  = ELEM_W'(8);
	localparam logic [ELEM_W-1:0]  ELEM_LIMIT  = ELEM_W'(65536);
	localparam logic [ALIGN_W-1:0] ALIGN_LIMIT = ALIGN_W'(4096);
	localparam logic [USED_W-1:0]  USED_LIMIT  = USED_W'(2047);

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;

	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_EMPTY     = 2'd1;
	localparam logic [1:0] STAT_NOT_OWNED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 3'd3;

	typedef enum logic [3:0] {
		SQ_STR_GO,
		SQ_STR_DIV,
		SQ_STR_FIN,
		SQ_SPAN,
		SQ_CLEAR,
		SQ_IDLE,
		SQ_ALLOC_MUL,
		SQ_ALLOC_ADD,
		SQ_OFFSET,
		SQ_RANGE,
		SQ_OWN_DIV,
		SQ_OWN_FIN,
		SQ_DONE
	} seq_state_t;

	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    rem;
		logic [DIV_W-1:0]    bits;
		logic [DIV_W-1:0]    divisor;
		logic [STEP_W-1:0]   steps;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_W-1:0]    rem;
		logic [DIV_W-1:0]    quo;
	} div_rsp_t;

endpackage

FILE: src/fspa_ram.sv
// ----------------------------------------------------------------------------
// fspa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fspa_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/fspa_div.sv
// ----------------------------------------------------------------------------
// fspa_div
// Shared restoring divider, one quotient bit per cycle. The partial remainder
// starts below the divisor and the dividend bits shift in from the top.
// ----------------------------------------------------------------------------
module fspa_div import fspa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  bits_q;
	logic [DIV_W-1:0]  dvsr_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, bits_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvsr_q};
	assign ge    = trial >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			bits_q <= '0;
			dvsr_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= req.rem;
				bits_q <= req.bits;
				dvsr_q <= req.divisor;
				cnt_q  <= req.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
				bits_q <= {bits_q[DIV_W-2:0], ge};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
	assign rsp.quo  = bits_q;

endmodule

FILE: src/fixed_slot_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator_top
// Pool of equal-size slots handed out from a LIFO free list kept in RAM.
//
//   channel  dir  handshake          beat contents
//   s_*      in   s_tvalid/s_tready  tuser action, tdata address
//   m_*      out  m_tvalid/m_tready  tuser status, tdata address/owned/used
//   cfg_*    in   cfg_we             register index and write data
//
// alloc: a multiply state and an add state from accept to result, skipped on an
// empty pool; free and query: offset and range states, then the shared divider
// that takes one quotient bit a cycle, skipped for an address outside the pool.
// After reset and after each element, align, total or base write the stride
// divide and a link clearing pass over all SLOT_MAX slots precede s_tready.
// A finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module fixed_slot_pool_allocator_top import fspa_pkg::*; #(
	parameter int SLOT_MAX      = 1024,
	parameter int DEFAULT_ALIGN = 64,
	parameter int ADDR_BITS     = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [((ADDR_BITS+7)/8)*8-1:0] s_tdata,  // address
	input  logic [1:0]                     s_tuser,  // action
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [((ADDR_BITS+19)/8)*8-1:0] m_tdata, // slot_address, owned, used_count
	output logic [1:0]                     m_tuser,  // status
	input  logic                           cfg_we,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [ADDR_BITS-1:0]           cfg_data
);

	localparam int IDX_W  = $clog2(SLOT_MAX);
	localparam int CNT_W  = $clog2(SLOT_MAX + 1);
	localparam int SPAN_W = STRIDE_W + CNT_W;
	localparam int PROD_W = STRIDE_W + IDX_W;
	localparam int OFF_W  = (ADDR_BITS + 1 > SPAN_W) ? ADDR_BITS + 1 : SPAN_W;
	localparam int OUT_W  = ((ADDR_BITS + 19) / 8) * 8;
	localparam int LINK_W = IDX_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_MAX - 1);

	seq_state_t state_q, state_d;

	logic [ELEM_W-1:0]    elem_q;
	logic [ALIGN_W-1:0]   align_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [ADDR_BITS-1:0] base_q;

	logic [CNT_W-1:0]     count_q;
	logic [STRIDE_W-1:0]  stride_q;
	logic [SPAN_W-1:0]    span_q;
	logic [IDX_W-1:0]     head_q;
	logic                 head_ok_q;
	logic [USED_W-1:0]    used_q;
	logic [IDX_W-1:0]     clr_q;

	logic [1:0]           act_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [OFF_W-1:0]     off_q;
	logic [PROD_W-1:0]    prod_q;
	logic [1:0]           res_status_q;
	logic [ADDR_BITS-1:0] res_addr_q;
	logic                 res_owned_q;

	logic                 m_valid_q;
	logic [1:0]           m_status_q;
	logic [ADDR_BITS-1:0] m_addr_q;
	logic                 m_owned_q;
	logic [USED_W-1:0]    m_used_q;

	logic [ELEM_W-1:0]    elem_eff;
	logic [ALIGN_W-1:0]   align_eff;
	logic [STRIDE_W-1:0]  str_dividend;
	logic [CNT_W-1:0]     count_eff;
	logic                 in_range;
	logic                 cfg_hit;
	logic                 out_load;
	logic [IDX_W-1:0]     own_idx;
	logic                 rem_zero;

	div_req_t             div_req;
	div_rsp_t             div_rsp;

	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [LINK_W-1:0]    mem_wdata;
	logic [LINK_W-1:0]    mem_rdata;

	fspa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	fspa_ram #(
		.WIDTH (LINK_W),
		.DEPTH (SLOT_MAX)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (head_q),
		.rdata (mem_rdata)
	);

	// stride rounding inputs
	always_comb begin
		if (elem_q < MIN_STRIDE) begin
			elem_eff = MIN_STRIDE;
		end else if (elem_q > ELEM_LIMIT) begin
			elem_eff = ELEM_LIMIT;
		end else begin
			elem_eff = elem_q;
		end
		if (align_q == '0) begin
			align_eff = ALIGN_W'(DEFAULT_ALIGN);
		end else if (align_q > ALIGN_LIMIT) begin
			align_eff = ALIGN_LIMIT;
		end else begin
			align_eff = align_q;
		end
	end

	assign str_dividend = elem_eff + STRIDE_W'(align_eff) - 1'b1;
	assign count_eff    = (32'(total_q) > SLOT_MAX) ? CNT_W'(SLOT_MAX) : CNT_W'(total_q);
	assign in_range     = (addr_q != '0) && !off_q[OFF_W-1] && (off_q < OFF_W'(span_q));
	assign own_idx      = div_rsp.quo[IDX_W-1:0];
	assign rem_zero     = div_rsp.rem == '0;
	assign cfg_hit      = cfg_we && (cfg_index == CFG_ELEMENT || cfg_index == CFG_ALIGN ||
	                                 cfg_index == CFG_TOTAL || cfg_index == CFG_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_STR_GO;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_req   = '0;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = (clr_q == '0) ? '0 : {1'b1, clr_q - 1'b1};
		s_tready  = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			SQ_STR_GO: begin
				div_req.start   = 1'b1;
				div_req.rem     = '0;
				div_req.bits    = str_dividend;
				div_req.divisor = STRIDE_W'(align_eff);
				div_req.steps   = STEP_W'(STRIDE_W);
				state_d         = SQ_STR_DIV;
			end
			SQ_STR_DIV: begin
				if (div_rsp.done) begin
					state_d = SQ_STR_FIN;
				end
			end
			SQ_STR_FIN: begin
				state_d = SQ_SPAN;
			end
			SQ_SPAN: begin
				state_d = SQ_CLEAR;
			end
			SQ_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == LAST_IDX) begin
					state_d = SQ_IDLE;
				end
			end
			SQ_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == ACT_ALLOC) begin
						state_d = head_ok_q ? SQ_ALLOC_MUL : SQ_DONE;
					end else begin
						state_d = SQ_OFFSET;
					end
				end
			end
			SQ_ALLOC_MUL: begin
				state_d = SQ_ALLOC_ADD;
			end
			SQ_ALLOC_ADD: begin
				state_d = SQ_DONE;
			end
			SQ_OFFSET: begin
				state_d = SQ_RANGE;
			end
			SQ_RANGE: begin
				if (in_range) begin
					div_req.start   = 1'b1;
					div_req.rem     = off_q[CNT_W +: DIV_W];
					div_req.bits    = DIV_W'(off_q[CNT_W-1:0]) << (DIV_W - CNT_W);
					div_req.divisor = stride_q;
					div_req.steps   = STEP_W'(CNT_W);
					state_d         = SQ_OWN_DIV;
				end else begin
					state_d = SQ_DONE;
				end
			end
			SQ_OWN_DIV: begin
				if (div_rsp.done) begin
					state_d = SQ_OWN_FIN;
				end
			end
			SQ_OWN_FIN: begin
				if (act_q == ACT_FREE && rem_zero) begin
					mem_we    = 1'b1;
					mem_waddr = own_idx;
					mem_wdata = {head_ok_q, head_q};
				end
				state_d = SQ_DONE;
			end
			SQ_DONE: begin
				if (!m_valid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = SQ_IDLE;
				end
			end
			default: begin
				state_d = SQ_STR_GO;
			end
		endcase
		if (cfg_hit) begin
			state_d = SQ_STR_GO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_q       <= ELEM_W'(8);
			align_q      <= '0;
			total_q      <= TOTAL_W'(1024);
			base_q       <= '0;
			count_q      <= '0;
			stride_q     <= '0;
			span_q       <= '0;
			head_q       <= '0;
			head_ok_q    <= 1'b0;
			used_q       <= '0;
			clr_q        <= '0;
			act_q        <= '0;
			addr_q       <= '0;
			off_q        <= '0;
			prod_q       <= '0;
			res_status_q <= STAT_DONE;
			res_addr_q   <= '0;
			res_owned_q  <= 1'b0;
			m_valid_q    <= 1'b0;
			m_status_q   <= STAT_DONE;
			m_addr_q     <= '0;
			m_owned_q    <= 1'b0;
			m_used_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ELEMENT: elem_q  <= cfg_data[ELEM_W-1:0];
					CFG_ALIGN:   align_q <= cfg_data[ALIGN_W-1:0];
					CFG_TOTAL:   total_q <= cfg_data[TOTAL_W-1:0];
					CFG_BASE:    base_q  <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				SQ_STR_GO: begin
					count_q <= count_eff;
					clr_q   <= '0;
				end
				SQ_STR_FIN: begin
					stride_q <= str_dividend - div_rsp.rem;
				end
				SQ_SPAN: begin
					span_q    <= SPAN_W'(stride_q) * SPAN_W'(count_q);
					head_ok_q <= count_q != '0;
					head_q    <= IDX_W'(count_q - 1'b1);
					used_q    <= '0;
				end
				SQ_CLEAR: begin
					clr_q <= clr_q + 1'b1;
				end
				SQ_IDLE: begin
					if (s_tvalid) begin
						act_q        <= s_tuser;
						addr_q       <= s_tdata[ADDR_BITS-1:0];
						res_status_q <= (s_tuser == ACT_ALLOC && !head_ok_q) ? STAT_EMPTY
						                                                      : STAT_DONE;
						res_addr_q   <= '0;
						res_owned_q  <= 1'b0;
					end
				end
				SQ_ALLOC_MUL: begin
					prod_q    <= PROD_W'(head_q) * PROD_W'(stride_q);
					head_q    <= mem_rdata[IDX_W-1:0];
					head_ok_q <= mem_rdata[IDX_W];
					if (used_q != USED_LIMIT) begin
						used_q <= used_q + 1'b1;
					end
				end
				SQ_ALLOC_ADD: begin
					res_addr_q <= base_q + ADDR_BITS'(prod_q);
				end
				SQ_OFFSET: begin
					off_q <= OFF_W'(addr_q) - OFF_W'(base_q);
				end
				SQ_RANGE: begin
					if (!in_range && act_q == ACT_FREE) begin
						res_status_q <= STAT_NOT_OWNED;
					end
				end
				SQ_OWN_FIN: begin
					if (rem_zero) begin
						res_owned_q <= 1'b1;
						if (act_q == ACT_FREE) begin
							head_q    <= own_idx;
							head_ok_q <= 1'b1;
							if (used_q != '0) begin
								used_q <= used_q - 1'b1;
							end
						end
					end else if (act_q == ACT_FREE) begin
						res_status_q <= STAT_NOT_OWNED;
					end
				end
				default: ;
			endcase

			if (out_load) begin
				m_valid_q  <= 1'b1;
				m_status_q <= res_status_q;
				m_addr_q   <= res_addr_q;
				m_owned_q  <= res_owned_q;
				m_used_q   <= used_q;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = OUT_W'({m_used_q, m_owned_q, m_addr_q});

endmodule
